// File: design/imh_pkg.sv
package imh_pkg;

  // Defaults for the top-level parameters.
  localparam int CapacityDef = 256;
  localparam int KeyBitsDef  = 32;

  // Fixed field widths.
  localparam int ID_W    = 8;
  localparam int NUM_IDS = 256;
  localparam int OP_W    = 2;
  localparam int ST_W    = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL_MIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC_KEY  = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    C_NONE,
    C_LOAD,
    C_FULL,
    C_PRESENT,
    C_ABSENT,
    C_EMPTY,
    C_INS,
    C_DK,
    C_UP_RD,
    C_UP_MOVE,
    C_PLACE,
    C_RD_ROOT,
    C_DEL,
    C_DEL_LAST,
    C_DN_RD,
    C_DN_L,
    C_DN_R,
    C_DN_MOVE,
    C_ROOT,
    C_NO_ROOT,
    C_OUT
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            one;
    logic            present;
    logic            at_root;
    logic            no_child;
    logic            has_right;
    logic            par_gt;
    logic            map_bad;
    logic            ent_gt_chd;
    logic            out_free;
  } sts_t;

endpackage

// File: design/imh_ram.sv
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/imh_ctrl.sv
module imh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  imh_pkg::sts_t    sts_i,
  output imh_pkg::cmd_e    cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_DK_RD    = 4'd2;
  localparam logic [3:0] S_UP_CHK   = 4'd3;
  localparam logic [3:0] S_UP_CMP   = 4'd4;
  localparam logic [3:0] S_DEL_RD   = 4'd5;
  localparam logic [3:0] S_DEL_LAST = 4'd6;
  localparam logic [3:0] S_DN_CHK   = 4'd7;
  localparam logic [3:0] S_DN_L     = 4'd8;
  localparam logic [3:0] S_DN_R     = 4'd9;
  localparam logic [3:0] S_DN_CMP   = 4'd10;
  localparam logic [3:0] S_ROOT     = 4'd11;
  localparam logic [3:0] S_ROOT_RD  = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  logic [3:0] state_q, state_d;

  // Next state and command.
  always_comb begin
    state_d = state_q;
    cmd_o   = imh_pkg::C_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = imh_pkg::C_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          imh_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o   = imh_pkg::C_FULL;
              state_d = S_ROOT;
            end else if (sts_i.present) begin
              cmd_o   = imh_pkg::C_PRESENT;
              state_d = S_ROOT;
            end else begin
              cmd_o   = imh_pkg::C_INS;
              state_d = S_UP_CHK;
            end
          end
          imh_pkg::OP_DEL_MIN: begin
            if (sts_i.empty) begin
              cmd_o   = imh_pkg::C_EMPTY;
              state_d = S_FIN;
            end else begin
              cmd_o   = imh_pkg::C_RD_ROOT;
              state_d = S_DEL_RD;
            end
          end
          imh_pkg::OP_DEC_KEY: begin
            if (sts_i.present) begin
              state_d = S_DK_RD;
            end else begin
              cmd_o   = imh_pkg::C_ABSENT;
              state_d = S_ROOT;
            end
          end
          default: state_d = S_ROOT;
        endcase
      end
      S_DK_RD: begin
        if (sts_i.map_bad) begin
          cmd_o   = imh_pkg::C_ABSENT;
          state_d = S_ROOT;
        end else begin
          cmd_o   = imh_pkg::C_DK;
          state_d = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts_i.at_root) begin
          cmd_o   = imh_pkg::C_PLACE;
          state_d = S_ROOT;
        end else begin
          cmd_o   = imh_pkg::C_UP_RD;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.par_gt) begin
          cmd_o   = imh_pkg::C_UP_MOVE;
          state_d = S_UP_CHK;
        end else begin
          cmd_o   = imh_pkg::C_PLACE;
          state_d = S_ROOT;
        end
      end
      S_DEL_RD: begin
        cmd_o   = imh_pkg::C_DEL;
        state_d = sts_i.one ? S_FIN : S_DEL_LAST;
      end
      S_DEL_LAST: begin
        cmd_o   = imh_pkg::C_DEL_LAST;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts_i.no_child) begin
          cmd_o   = imh_pkg::C_PLACE;
          state_d = S_FIN;
        end else begin
          cmd_o   = imh_pkg::C_DN_RD;
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd_o   = imh_pkg::C_DN_L;
        state_d = sts_i.has_right ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        cmd_o   = imh_pkg::C_DN_R;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.ent_gt_chd) begin
          cmd_o   = imh_pkg::C_DN_MOVE;
          state_d = S_DN_CHK;
        end else begin
          cmd_o   = imh_pkg::C_PLACE;
          state_d = S_FIN;
        end
      end
      S_ROOT: begin
        if (sts_i.empty) begin
          cmd_o   = imh_pkg::C_NO_ROOT;
          state_d = S_FIN;
        end else begin
          cmd_o   = imh_pkg::C_RD_ROOT;
          state_d = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        cmd_o   = imh_pkg::C_ROOT;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o   = imh_pkg::C_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// File: design/imh_dp.sv
module imh_dp #(
  parameter int Capacity = imh_pkg::CapacityDef,
  parameter int KeyBits  = imh_pkg::KeyBitsDef,
  localparam int AW      = $clog2(Capacity + 1),
  localparam int EW      = imh_pkg::ID_W + KeyBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  imh_pkg::cmd_e            cmd_i,
  output imh_pkg::sts_t            sts_o,
  input  logic [imh_pkg::OP_W-1:0] in_op_i,
  input  logic [imh_pkg::ID_W-1:0] in_id_i,
  input  logic [KeyBits-1:0]       in_key_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [imh_pkg::ID_W-1:0] out_id_o,
  output logic [KeyBits-1:0]       out_key_o,
  output logic                     out_vld_o,
  output logic [AW-1:0]            out_cnt_o,
  output logic [imh_pkg::ST_W-1:0] out_status_o
);

  // Control state.
  logic [AW-1:0]                cnt_q;
  logic [imh_pkg::NUM_IDS-1:0]  vld_q;
  logic                         out_valid_q;

  // Working registers.
  logic [imh_pkg::OP_W-1:0] op_q;
  logic [imh_pkg::ID_W-1:0] id_q;
  logic [KeyBits-1:0]       key_q;
  logic [imh_pkg::ST_W-1:0] status_q;
  logic [AW-1:0]            slot_q;
  logic [AW-1:0]            chs_q;
  logic [EW-1:0]            ent_q;
  logic [EW-1:0]            chd_q;
  logic [EW-1:0]            res_q;
  logic                     res_vld_q;

  // Output register.
  logic [EW-1:0]            out_ent_q;
  logic                     out_vld_q;
  logic [AW-1:0]            out_cnt_q;
  logic [imh_pkg::ST_W-1:0] out_status_q;

  // Memory ports.
  logic          hwe, mwe;
  logic [AW-1:0] hwaddr, hraddr, mwdata, m_rd;
  logic [EW-1:0] hwdata, h_rd;
  logic [imh_pkg::ID_W-1:0] mwaddr;

  // Child slot arithmetic, one bit wider than a slot.
  logic [AW:0] c_wide, cr_wide;
  assign c_wide  = {slot_q, 1'b0};
  assign cr_wide = {slot_q, 1'b1};

  // Heap of {id, key} by slot, slot 1 is the root.
  imh_ram #(.Width(EW), .Depth(Capacity + 1)) u_heap (
    .clk_i   (clk_i),
    .we_i    (hwe),
    .waddr_i (hwaddr),
    .wdata_i (hwdata),
    .raddr_i (hraddr),
    .rdata_o (h_rd)
  );

  // Slot of each id; vld_q says which entries hold a slot.
  imh_ram #(.Width(AW), .Depth(imh_pkg::NUM_IDS)) u_map (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (mwaddr),
    .wdata_i (mwdata),
    .raddr_i (id_q),
    .rdata_o (m_rd)
  );

  // Memory addressing per command.
  always_comb begin
    hwe    = 1'b0;
    hwaddr = slot_q;
    hwdata = ent_q;
    hraddr = AW'(1);
    mwe    = 1'b0;
    mwaddr = ent_q[EW-1:KeyBits];
    mwdata = slot_q;
    case (cmd_i)
      imh_pkg::C_UP_RD: hraddr = slot_q >> 1;
      imh_pkg::C_DEL:   hraddr = cnt_q;
      imh_pkg::C_DN_RD: hraddr = c_wide[AW-1:0];
      imh_pkg::C_DN_L:  hraddr = cr_wide[AW-1:0];
      imh_pkg::C_PLACE: begin
        hwe = 1'b1;
        mwe = 1'b1;
      end
      imh_pkg::C_UP_MOVE: begin
        hwe    = 1'b1;
        hwdata = h_rd;
        mwe    = 1'b1;
        mwaddr = h_rd[EW-1:KeyBits];
      end
      imh_pkg::C_DN_MOVE: begin
        hwe    = 1'b1;
        hwdata = chd_q;
        mwe    = 1'b1;
        mwaddr = chd_q[EW-1:KeyBits];
      end
      default: hraddr = AW'(1);
    endcase
  end

  // Count, presence bits and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        imh_pkg::C_INS: begin
          cnt_q       <= cnt_q + AW'(1);
          vld_q[id_q] <= 1'b1;
        end
        imh_pkg::C_DEL: begin
          cnt_q                        <= cnt_q - AW'(1);
          vld_q[h_rd[EW-1:KeyBits]]    <= 1'b0;
        end
        default: cnt_q <= cnt_q;
      endcase
      if (cmd_i == imh_pkg::C_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      imh_pkg::C_LOAD: begin
        op_q     <= in_op_i;
        id_q     <= in_id_i;
        key_q    <= in_key_i;
        status_q <= imh_pkg::ST_OK;
      end
      imh_pkg::C_FULL:    status_q <= imh_pkg::ST_FULL;
      imh_pkg::C_PRESENT: status_q <= imh_pkg::ST_PRESENT;
      imh_pkg::C_ABSENT:  status_q <= imh_pkg::ST_ABSENT;
      imh_pkg::C_EMPTY: begin
        status_q  <= imh_pkg::ST_EMPTY;
        res_q     <= '0;
        res_vld_q <= 1'b0;
      end
      imh_pkg::C_INS: begin
        slot_q <= cnt_q + AW'(1);
        ent_q  <= {id_q, key_q};
      end
      imh_pkg::C_DK: begin
        slot_q <= m_rd;
        ent_q  <= {id_q, key_q};
      end
      imh_pkg::C_UP_MOVE: slot_q <= slot_q >> 1;
      imh_pkg::C_DEL: begin
        res_q     <= h_rd;
        res_vld_q <= 1'b1;
      end
      imh_pkg::C_DEL_LAST: begin
        ent_q  <= h_rd;
        slot_q <= AW'(1);
      end
      imh_pkg::C_DN_L: begin
        chd_q <= h_rd;
        chs_q <= c_wide[AW-1:0];
      end
      imh_pkg::C_DN_R: begin
        // Ties keep the left child.
        if (chd_q[KeyBits-1:0] > h_rd[KeyBits-1:0]) begin
          chd_q <= h_rd;
          chs_q <= cr_wide[AW-1:0];
        end
      end
      imh_pkg::C_DN_MOVE: slot_q <= chs_q;
      imh_pkg::C_ROOT: begin
        res_q     <= h_rd;
        res_vld_q <= 1'b1;
      end
      imh_pkg::C_NO_ROOT: begin
        res_q     <= '0;
        res_vld_q <= 1'b0;
      end
      imh_pkg::C_OUT: begin
        out_ent_q    <= res_q;
        out_vld_q    <= res_vld_q;
        out_cnt_q    <= cnt_q;
        out_status_q <= status_q;
      end
      default: slot_q <= slot_q;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts_o.op         = op_q;
    sts_o.full       = (cnt_q == AW'(Capacity));
    sts_o.empty      = (cnt_q == '0);
    sts_o.one        = (cnt_q == AW'(1));
    sts_o.present    = vld_q[id_q];
    sts_o.at_root    = (slot_q == AW'(1));
    sts_o.no_child   = (c_wide > {1'b0, cnt_q});
    sts_o.has_right  = (c_wide < {1'b0, cnt_q});
    sts_o.par_gt     = (h_rd[KeyBits-1:0] > ent_q[KeyBits-1:0]);
    sts_o.map_bad    = (m_rd == '0) || (m_rd > cnt_q);
    sts_o.ent_gt_chd = (ent_q[KeyBits-1:0] > chd_q[KeyBits-1:0]);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_id_o     = out_ent_q[EW-1:KeyBits];
  assign out_key_o    = out_ent_q[KeyBits-1:0];
  assign out_vld_o    = out_vld_q;
  assign out_cnt_o    = out_cnt_q;
  assign out_status_o = out_status_q;

endmodule

// File: design/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap of 8-bit ids keyed by an unsigned fixed-point weight.
// Input stream (s_axis): one item is one operation: insert, delete-minimum or
// decrease-key. Output stream (m_axis): exactly one result item per operation,
// carrying the removed minimum (delete) or the current minimum, the entry count
// and a status code.
// One operation at a time: the block takes no new item until it has issued the
// result item of the last one. An insert climbs the heap level by level toward the
// root, a decrease-key first reads the slot of its id and then climbs the same way,
// and a delete-minimum descends level by level. The heap memory has a single read
// port, which every level of a sift must pass through.
// Reset clears the count and every id's presence bit at once; the heap memory
// needs no clearing, so the block is ready for an item as soon as reset ends.
// The result sits in an output register: the block accepts the next item while
// it waits, and only holds off finishing that item while the receiver stalls.
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY = imh_pkg::CapacityDef,
  parameter int KEY_BITS = imh_pkg::KeyBitsDef,
  localparam int AW      = $clog2(CAPACITY + 1),
  localparam int InW     = imh_pkg::OP_W + imh_pkg::ID_W + KEY_BITS,
  localparam int InPW    = ((InW + 7) / 8) * 8,
  localparam int OutW    = imh_pkg::ID_W + KEY_BITS + 1 + AW + imh_pkg::ST_W,
  localparam int OutPW   = ((OutW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: operation, node_id, key.
  input  logic [InPW-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0 up: result_id, result_key, result_valid, entry_count, status.
  output logic [OutPW-1:0] m_axis_tdata
);

  imh_pkg::cmd_e cmd;
  imh_pkg::sts_t sts;

  logic [imh_pkg::ID_W-1:0] res_id;
  logic [KEY_BITS-1:0]      res_key;
  logic                     res_vld;
  logic [AW-1:0]            res_cnt;
  logic [imh_pkg::ST_W-1:0] res_status;

  // Sequencer.
  imh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Heap storage and registers.
  imh_dp #(.Capacity(CAPACITY), .KeyBits(KEY_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tdata[imh_pkg::OP_W-1:0]),
    .in_id_i      (s_axis_tdata[imh_pkg::OP_W +: imh_pkg::ID_W]),
    .in_key_i     (s_axis_tdata[imh_pkg::OP_W + imh_pkg::ID_W +: KEY_BITS]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_id_o     (res_id),
    .out_key_o    (res_key),
    .out_vld_o    (res_vld),
    .out_cnt_o    (res_cnt),
    .out_status_o (res_status)
  );

  // Pack the result item.
  assign m_axis_tdata = OutPW'({res_status, res_cnt, res_vld, res_key, res_id});

  // No second item is taken while one is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

  // The count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_cnt <= AW'(CAPACITY))
    else $error("entry count above capacity");

  // An empty delete carries no entry and leaves the heap empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_status == imh_pkg::ST_EMPTY |-> !res_vld && res_cnt == '0)
    else $error("empty status with an entry");

  // A result without an entry comes only from an empty heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_vld |-> res_cnt == '0)
    else $error("no entry reported from a non-empty heap");

endmodule
